// File: rtl/tmfs_pkg.sv
// Shared types and constants for the triangle metrics pipeline.
package tmfs_pkg;

	localparam int LEN_W         = 24;
	localparam int ID_W          = 16;
	localparam int AREA_W        = 40;
	localparam int ANG_W         = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int ID_BITS_DEF   = 16;

	// Heron radicand and its root
	localparam int SUM_W  = LEN_W + 2;
	localparam int DIF_W  = LEN_W + 1;
	localparam int P1_W   = SUM_W + DIF_W;
	localparam int P2_W   = 2 * DIF_W;
	localparam int HALF_W = 26;
	localparam int PART_W = 2 * HALF_W;
	localparam int ROOT_W = 51;
	localparam int RAD_W  = 2 * ROOT_W;

	// altitude division, leg and angle arithmetic
	localparam int ALT_STEPS    = LEN_W;
	localparam int SQ_W         = 2 * LEN_W;
	localparam int AQ_W         = 30;
	localparam int AREM_W       = 2 * LEN_W + 2;
	localparam int ADEN_W       = 2 * LEN_W + 1;
	localparam int P_W          = 2 * AQ_W + 1;
	localparam int YRAD_W       = 2 * (AQ_W + 1);
	localparam int CX_W         = 34;
	localparam int CZ_W         = 26;
	localparam int CORDIC_STEPS = 23;

	localparam logic [ANG_W-1:0]      ANGLE_MAX = 16'd46080;
	localparam logic signed [CZ_W-1:0] Z_MAX    = 26'sd11796480;
	localparam logic signed [CZ_W-1:0] Z_90     = 26'sd5898240;
	localparam logic signed [CZ_W-1:0] Z_HALF   = 26'sd128;

	// arctangent of 2^-i in degrees Q8.16
	localparam logic signed [CZ_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
		26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
		26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115,
		26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1
	};

	typedef struct packed {
		logic [LEN_W-1:0] base_length;
		logic [LEN_W-1:0] adj_length;
		logic [LEN_W-1:0] opposite_length;
		logic [ID_W-1:0]  base_target;
		logic [ID_W-1:0]  adj_target;
		logic [ID_W-1:0]  query_node;
	} tmfs_in_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic [ANG_W-1:0]  angle_degrees;
		logic [LEN_W-1:0]  altitude;
		logic [LEN_W-1:0]  leg_length;
		logic              status;
	} tmfs_out_t;

	// per-item context carried down the whole pipeline
	typedef struct packed {
		logic [LEN_W-1:0]        a;
		logic [LEN_W-1:0]        b;
		logic [LEN_W-1:0]        c;
		logic [LEN_W-1:0]        side;
		logic                    match;
		logic                    a_zero;
		logic                    bc_zero;
		logic                    alt_sat;
		logic                    leg_go;
		logic                    ang_neg;
		logic                    ang_ext;
		logic [ROOT_W-1:0]       root;
		logic [AREA_W-1:0]       area;
		logic [LEN_W+1:0]        drem;
		logic [LEN_W-1:0]        dnum;
		logic [LEN_W-1:0]        alt;
		logic [LEN_W-1:0]        leg;
		logic [AREM_W-1:0]       arem;
		logic [ADEN_W-1:0]       aden;
		logic [AQ_W-1:0]         aq;
		logic [P_W-1:0]          p0;
		logic [P_W-1:0]          p1;
		logic [P_W-1:0]          p2;
		logic [P_W-1:0]          p3;
		logic signed [CX_W-1:0]  cx;
		logic signed [CX_W-1:0]  cy;
		logic signed [CZ_W-1:0]  cz;
	} tmfs_ctx_t;

endpackage

// File: rtl/tmfs_ifs.sv
// Valid/ready channel interfaces for triangle requests and results.
interface tmfs_req_if import tmfs_pkg::*;;
	logic     valid;
	logic     ready;
	tmfs_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tmfs_res_if import tmfs_pkg::*;;
	logic      valid;
	logic      ready;
	tmfs_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/triangle_metrics_from_sides_unit.sv
// Triangle metrics unit: area, apex angle, altitude and leg from three sides.
//
// Takes one triangle transaction per clock, unless the result side stalls, and
// returns one result transaction per triangle, in order. Most stages hold one
// step of work (one root bit, one quotient bit, one CORDIC rotation or one
// multiply), so the rate is one transaction per cycle while unstalled; the depth is
// set by the chain of three bit-serial square roots (51, 24 and 31 stages), two
// restoring dividers (24 and 30 stages) and a 23-step CORDIC. The whole pipe
// moves on one enable: it advances whenever the output register is empty or
// being read, so a stall on the result side freezes every stage in place and
// request.ready drops with it. Area is floor(sqrt(Heron product)) scaled by
// FRAC_BITS+2 and saturated; status flags a zero side used as a divisor.
module triangle_metrics_from_sides_unit import tmfs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ID_BITS   = ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tmfs_req_if.sink    request,
	tmfs_res_if.source  result
);
	localparam int CTX_W  = $bits(tmfs_ctx_t);
	localparam int ID_CMP = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_CMP);

	// global pipeline advance
	logic      en;
	logic      res_vld_q;
	tmfs_out_t res_q;

	assign en            = !res_vld_q || result.ready;
	assign request.ready = en;

	// ---------------- stage 1: input register ----------------
	logic     raw_vld_s1;
	tmfs_in_t raw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_vld_s1 <= 1'b0;
		end else if (en) begin
			raw_vld_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= request.data;
		end
	end

	// ---------------- stage 2: side sums, validity, id match ----------------
	logic             fr_vld_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [DIF_W-1:0] d1_s2, d2_s2, d3_s2;
	logic             ok_s2;
	tmfs_ctx_t        fr_ctx_s2;

	logic [DIF_W-1:0] sbc, sac, sab;
	logic             base_hit, adj_hit;
	tmfs_ctx_t        fr_ctx_n;

	always_comb begin
		sbc      = {1'b0, raw_s1.adj_length} + {1'b0, raw_s1.base_length};
		sac      = {1'b0, raw_s1.opposite_length} + {1'b0, raw_s1.base_length};
		sab      = {1'b0, raw_s1.opposite_length} + {1'b0, raw_s1.adj_length};
		base_hit = (raw_s1.base_target & ID_MASK) == (raw_s1.query_node & ID_MASK);
		adj_hit  = (raw_s1.adj_target & ID_MASK) == (raw_s1.query_node & ID_MASK);

		fr_ctx_n         = '0;
		fr_ctx_n.a       = raw_s1.opposite_length;
		fr_ctx_n.b       = raw_s1.adj_length;
		fr_ctx_n.c       = raw_s1.base_length;
		// adjacent side wins when both ids match
		fr_ctx_n.side    = adj_hit ? raw_s1.adj_length : raw_s1.base_length;
		fr_ctx_n.match   = base_hit || adj_hit;
		fr_ctx_n.a_zero  = raw_s1.opposite_length == '0;
		fr_ctx_n.bc_zero = (raw_s1.adj_length == '0) || (raw_s1.base_length == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_s2 <= 1'b0;
		end else if (en) begin
			fr_vld_s2 <= raw_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2    <= {2'b0, raw_s1.opposite_length} + {2'b0, raw_s1.adj_length}
				+ {2'b0, raw_s1.base_length};
			d1_s2     <= sbc - {1'b0, raw_s1.opposite_length};
			d2_s2     <= sac - {1'b0, raw_s1.adj_length};
			d3_s2     <= sab - {1'b0, raw_s1.base_length};
			ok_s2     <= (sbc > {1'b0, raw_s1.opposite_length})
				&& (sac > {1'b0, raw_s1.adj_length})
				&& (sab > {1'b0, raw_s1.base_length});
			fr_ctx_s2 <= fr_ctx_n;
		end
	end

	// ---------------- stage 3: two half products of Heron's radicand ----------------
	logic            fr_vld_s3;
	logic [P1_W-1:0] p1_s3;
	logic [P2_W-1:0] p2_s3;
	tmfs_ctx_t       fr_ctx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_s3 <= 1'b0;
		end else if (en) begin
			fr_vld_s3 <= fr_vld_s2;
		end
	end

	// impossible or degenerate triangle: radicand forced to zero
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s3     <= ok_s2 ? P1_W'(sum_s2) * P1_W'(d1_s2) : '0;
			p2_s3     <= ok_s2 ? P2_W'(d2_s2) * P2_W'(d3_s2) : '0;
			fr_ctx_s3 <= fr_ctx_s2;
		end
	end

	// ---------------- stage 4: cross partial products ----------------
	logic              fr_vld_s4;
	logic [PART_W-1:0] hh_s4, hl_s4, lh_s4, ll_s4;
	tmfs_ctx_t         fr_ctx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_s4 <= 1'b0;
		end else if (en) begin
			fr_vld_s4 <= fr_vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s4     <= PART_W'(p1_s3[P1_W-1:HALF_W]) * PART_W'(p2_s3[P2_W-1:HALF_W]);
			hl_s4     <= PART_W'(p1_s3[P1_W-1:HALF_W]) * PART_W'(p2_s3[HALF_W-1:0]);
			lh_s4     <= PART_W'(p1_s3[HALF_W-1:0]) * PART_W'(p2_s3[P2_W-1:HALF_W]);
			ll_s4     <= PART_W'(p1_s3[HALF_W-1:0]) * PART_W'(p2_s3[HALF_W-1:0]);
			fr_ctx_s4 <= fr_ctx_s3;
		end
	end

	// ---------------- stage 5: full radicand ----------------
	logic             fr_vld_s5;
	logic [RAD_W-1:0] rad_s5;
	tmfs_ctx_t        fr_ctx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_s5 <= 1'b0;
		end else if (en) begin
			fr_vld_s5 <= fr_vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5    <= (RAD_W'(hh_s4) << (2 * HALF_W))
				+ ((RAD_W'(hl_s4) + RAD_W'(lh_s4)) << HALF_W) + RAD_W'(ll_s4);
			fr_ctx_s5 <= fr_ctx_s4;
		end
	end

	// ---------------- Heron root ----------------
	logic              sqa_vld;
	logic [ROOT_W-1:0] sqa_root;
	logic [CTX_W-1:0]  sqa_side;
	tmfs_ctx_t         sqa_ctx;

	tmfs_sqrt_pipe #(
		.RAD_W  (RAD_W),
		.SIDE_W (CTX_W)
	) u_sqrt_area (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_vld_s5),
		.rad       (rad_s5),
		.side      (CTX_W'(fr_ctx_s5)),
		.out_valid (sqa_vld),
		.root      (sqa_root),
		.out_side  (sqa_side)
	);

	assign sqa_ctx = tmfs_ctx_t'(sqa_side);

	// ---------------- area, altitude overflow check, divider setup ----------------
	logic      ad_vld_s [0:ALT_STEPS];
	tmfs_ctx_t ad_s     [0:ALT_STEPS];

	logic [ROOT_W-1:0] area_sh;
	tmfs_ctx_t         ar_ctx_n;

	always_comb begin
		area_sh          = sqa_root >> (FRAC_BITS + 2);
		ar_ctx_n         = sqa_ctx;
		ar_ctx_n.root    = sqa_root;
		ar_ctx_n.area    = (|area_sh[ROOT_W-1:AREA_W]) ? '1 : area_sh[AREA_W-1:0];
		// quotient needs more than LEN_W bits: altitude saturates
		ar_ctx_n.alt_sat = sqa_root >= ROOT_W'({sqa_ctx.a, 1'b0, {LEN_W{1'b0}}});
		ar_ctx_n.drem    = sqa_root[LEN_W +: LEN_W+2];
		ar_ctx_n.dnum    = sqa_root[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_vld_s[0] <= 1'b0;
		end else if (en) begin
			ad_vld_s[0] <= sqa_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s[0] <= ar_ctx_n;
		end
	end

	// ---------------- altitude = root / (2a), one quotient bit per stage ----------------
	for (genvar i = 0; i < ALT_STEPS; i++) begin : g_alt_div
		logic [LEN_W+1:0] rn, dv;
		logic             take;
		tmfs_ctx_t        nx;

		always_comb begin
			rn      = {ad_s[i].drem[LEN_W:0], ad_s[i].dnum[LEN_W-1]};
			dv      = {1'b0, ad_s[i].a, 1'b0};
			take    = rn >= dv;
			nx      = ad_s[i];
			nx.drem = take ? rn - dv : rn;
			nx.dnum = {ad_s[i].dnum[LEN_W-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ad_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				ad_vld_s[i+1] <= ad_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ad_s[i+1] <= nx;
			end
		end
	end

	// ---------------- leg preparation ----------------
	logic      lg_vld_s1, lg_vld_s2, lg_vld_s3;
	tmfs_ctx_t lg_s1, lg_s2, lg_s3;
	tmfs_ctx_t lg1_n, lg2_n, lg3_n;

	always_comb begin
		lg1_n     = ad_s[ALT_STEPS];
		lg1_n.alt = ad_s[ALT_STEPS].a_zero ? '0
			: (ad_s[ALT_STEPS].alt_sat ? '1 : ad_s[ALT_STEPS].dnum);

		lg2_n        = lg_s1;
		lg2_n.p0     = P_W'(lg_s1.side) * P_W'(lg_s1.side);
		lg2_n.p1     = P_W'(lg_s1.alt) * P_W'(lg_s1.alt);
		lg2_n.leg_go = lg_s1.match && !lg_s1.a_zero && (lg_s1.side > lg_s1.alt);

		lg3_n    = lg_s2;
		lg3_n.p2 = lg_s2.leg_go ? lg_s2.p0 - lg_s2.p1 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_vld_s1 <= 1'b0;
			lg_vld_s2 <= 1'b0;
			lg_vld_s3 <= 1'b0;
		end else if (en) begin
			lg_vld_s1 <= ad_vld_s[ALT_STEPS];
			lg_vld_s2 <= lg_vld_s1;
			lg_vld_s3 <= lg_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lg_s1 <= lg1_n;
			lg_s2 <= lg2_n;
			lg_s3 <= lg3_n;
		end
	end

	// ---------------- leg root ----------------
	logic             sqb_vld;
	logic [LEN_W-1:0] sqb_root;
	logic [CTX_W-1:0] sqb_side;
	tmfs_ctx_t        sqb_ctx;

	tmfs_sqrt_pipe #(
		.RAD_W  (SQ_W),
		.SIDE_W (CTX_W)
	) u_sqrt_leg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (lg_vld_s3),
		.rad       (lg_s3.p2[SQ_W-1:0]),
		.side      (CTX_W'(lg_s3)),
		.out_valid (sqb_vld),
		.root      (sqb_root),
		.out_side  (sqb_side)
	);

	assign sqb_ctx = tmfs_ctx_t'(sqb_side);

	// ---------------- angle setup: squares, numerator and denominator ----------------
	logic      an_vld_s1, an_vld_s2;
	tmfs_ctx_t an_s1, an_s2;
	tmfs_ctx_t an1_n, an2_n, an3_n;
	logic [ADEN_W-1:0] bbcc;

	logic      av_vld_s [0:AQ_W];
	tmfs_ctx_t av_s     [0:AQ_W];

	always_comb begin
		an1_n     = sqb_ctx;
		an1_n.leg = sqb_root;
		an1_n.p0  = P_W'(sqb_ctx.a) * P_W'(sqb_ctx.a);
		an1_n.p1  = P_W'(sqb_ctx.b) * P_W'(sqb_ctx.b);
		an1_n.p2  = P_W'(sqb_ctx.c) * P_W'(sqb_ctx.c);
		an1_n.p3  = P_W'(sqb_ctx.b) * P_W'(sqb_ctx.c);

		bbcc          = ADEN_W'(an_s1.p1) + ADEN_W'(an_s1.p2);
		an2_n         = an_s1;
		an2_n.ang_neg = ADEN_W'(an_s1.p0) > bbcc;
		an2_n.arem    = an2_n.ang_neg ? AREM_W'(ADEN_W'(an_s1.p0) - bbcc)
			: AREM_W'(bbcc - ADEN_W'(an_s1.p0));
		an2_n.aden    = {an_s1.p3[SQ_W-1:0], 1'b0};

		// cosine at or beyond +-1: angle is exactly 0 or 180 degrees
		an3_n         = an_s2;
		an3_n.ang_ext = an_s2.arem >= AREM_W'(an_s2.aden);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			an_vld_s1   <= 1'b0;
			an_vld_s2   <= 1'b0;
			av_vld_s[0] <= 1'b0;
		end else if (en) begin
			an_vld_s1   <= sqb_vld;
			an_vld_s2   <= an_vld_s1;
			av_vld_s[0] <= an_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1   <= an1_n;
			an_s2   <= an2_n;
			av_s[0] <= an3_n;
		end
	end

	// ---------------- |cos| in Q0.30, one quotient bit per stage ----------------
	for (genvar i = 0; i < AQ_W; i++) begin : g_cos_div
		logic [AREM_W-1:0] rn;
		logic              take;
		tmfs_ctx_t         nx;

		always_comb begin
			rn      = {av_s[i].arem[AREM_W-2:0], 1'b0};
			take    = rn >= AREM_W'(av_s[i].aden);
			nx      = av_s[i];
			nx.arem = take ? rn - AREM_W'(av_s[i].aden) : rn;
			nx.aq   = {av_s[i].aq[AQ_W-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				av_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				av_vld_s[i+1] <= av_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				av_s[i+1] <= nx;
			end
		end
	end

	// ---------------- sine radicand: 2^60 - cos^2 ----------------
	logic      ay_vld_s1, ay_vld_s2;
	tmfs_ctx_t ay_s1, ay_s2;
	tmfs_ctx_t ay1_n, ay2_n;

	always_comb begin
		ay1_n    = av_s[AQ_W];
		ay1_n.p0 = P_W'(av_s[AQ_W].aq) * P_W'(av_s[AQ_W].aq);

		ay2_n    = ay_s1;
		ay2_n.p1 = (P_W'(1) << (2 * AQ_W)) - ay_s1.p0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ay_vld_s1 <= 1'b0;
			ay_vld_s2 <= 1'b0;
		end else if (en) begin
			ay_vld_s1 <= av_vld_s[AQ_W];
			ay_vld_s2 <= ay_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s1 <= ay1_n;
			ay_s2 <= ay2_n;
		end
	end

	logic              sqc_vld;
	logic [AQ_W:0]     sqc_root;
	logic [CTX_W-1:0]  sqc_side;
	tmfs_ctx_t         sqc_ctx;

	tmfs_sqrt_pipe #(
		.RAD_W  (YRAD_W),
		.SIDE_W (CTX_W)
	) u_sqrt_sin (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ay_vld_s2),
		.rad       (YRAD_W'(ay_s2.p1)),
		.side      (CTX_W'(ay_s2)),
		.out_valid (sqc_vld),
		.root      (sqc_root),
		.out_side  (sqc_side)
	);

	assign sqc_ctx = tmfs_ctx_t'(sqc_side);

	// ---------------- CORDIC vectoring: atan2(sin, cos) in degrees ----------------
	logic      cr_vld_s [0:CORDIC_STEPS];
	tmfs_ctx_t cr_s     [0:CORDIC_STEPS];
	tmfs_ctx_t cr0_n;

	// negative cosine: pre-rotate by 90 degrees so x starts non-negative;
	// a cosine that truncates to zero counts as non-negative
	always_comb begin
		cr0_n = sqc_ctx;
		if (sqc_ctx.ang_neg && (sqc_ctx.aq != '0)) begin
			cr0_n.cx = CX_W'(sqc_root);
			cr0_n.cy = CX_W'(sqc_ctx.aq);
			cr0_n.cz = Z_90;
		end else begin
			cr0_n.cx = CX_W'(sqc_ctx.aq);
			cr0_n.cy = CX_W'(sqc_root);
			cr0_n.cz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_vld_s[0] <= 1'b0;
		end else if (en) begin
			cr_vld_s[0] <= sqc_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s[0] <= cr0_n;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		tmfs_ctx_t nx;

		always_comb begin
			nx = cr_s[i];
			if (!cr_s[i].cy[CX_W-1]) begin
				nx.cx = cr_s[i].cx + (cr_s[i].cy >>> i);
				nx.cy = cr_s[i].cy - (cr_s[i].cx >>> i);
				nx.cz = cr_s[i].cz + ATAN_DEG[i];
			end else begin
				nx.cx = cr_s[i].cx - (cr_s[i].cy >>> i);
				nx.cy = cr_s[i].cy + (cr_s[i].cx >>> i);
				nx.cz = cr_s[i].cz - ATAN_DEG[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				cr_vld_s[i+1] <= cr_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cr_s[i+1] <= nx;
			end
		end
	end

	// ---------------- result: clamp and round angle, pick special cases ----------------
	tmfs_ctx_t              fin;
	logic signed [CZ_W-1:0] z_clamp;
	logic signed [CZ_W-1:0] z_round;
	logic [ANG_W-1:0]       ang_cordic;
	tmfs_out_t              res_n;

	always_comb begin
		fin = cr_s[CORDIC_STEPS];
		priority if (fin.cz < 0) begin
			z_clamp = '0;
		end else if (fin.cz > Z_MAX) begin
			z_clamp = Z_MAX;
		end else begin
			z_clamp = fin.cz;
		end
		z_round    = z_clamp + Z_HALF;
		ang_cordic = z_round[ANG_W+7:8];

		res_n.area     = fin.area;
		res_n.altitude = fin.alt;
		res_n.leg_length = fin.leg;
		res_n.status   = fin.a_zero || fin.bc_zero;
		priority if (fin.bc_zero) begin
			res_n.angle_degrees = '0;
		end else if (fin.ang_ext) begin
			res_n.angle_degrees = fin.ang_neg ? ANGLE_MAX : '0;
		end else begin
			res_n.angle_degrees = ang_cordic;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= cr_vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_n;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;
endmodule

// File: rtl/tmfs_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with side data.
module tmfs_sqrt_pipe #(
	parameter int RAD_W  = 2,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     rad,
	input  logic [SIDE_W-1:0]    side,
	output logic                 out_valid,
	output logic [RAD_W/2-1:0]   root,
	output logic [SIDE_W-1:0]    out_side
);
	localparam int ROOT_W = RAD_W / 2;

	logic                vld_s  [1:ROOT_W];
	logic [ROOT_W+1:0]   rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]   root_s [1:ROOT_W];
	logic [RAD_W-1:0]    rad_s  [1:ROOT_W];
	logic [SIDE_W-1:0]   side_s [1:ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		logic              vld_p;
		logic [ROOT_W+1:0] rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [RAD_W-1:0]  rad_p;
		logic [SIDE_W-1:0] side_p;
		logic [ROOT_W+1:0] rem_n;
		logic [ROOT_W+1:0] trial;
		logic              take;

		if (i == 0) begin : g_src
			assign vld_p  = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
			assign side_p = side;
		end else begin : g_src
			assign vld_p  = vld_s[i];
			assign rem_p  = rem_s[i];
			assign root_p = root_s[i];
			assign rad_p  = rad_s[i];
			assign side_p = side_s[i];
		end

		always_comb begin
			rem_n = {rem_p[ROOT_W-1:0], rad_p[RAD_W-1 -: 2]};
			trial = {root_p, 2'b01};
			take  = rem_n >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? rem_n - trial : rem_n;
				root_s[i+1] <= {root_p[ROOT_W-2:0], take};
				rad_s[i+1]  <= rad_p << 2;
				side_s[i+1] <= side_p;
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];
endmodule

// File: sim/triangle_metrics_from_sides_unit_tb.sv
// Testbench for the triangle metrics unit: directed table plus random triangles, self-checked.
module triangle_metrics_from_sides_unit_tb import tmfs_pkg::*;;

	localparam int N_RANDOM    = 830;
	localparam int LATENCY     = 199;
	localparam int IDLE_LIMIT  = 20000;
	localparam int STALL_LONG  = 600;

	typedef struct {
		tmfs_in_t  stim;
		bit        typed;
		tmfs_out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	tmfs_req_if request ();
	tmfs_res_if result ();

	triangle_metrics_from_sides_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request.sink),
		.result (result.source)
	);

	always #1 clk = ~clk;

	// expected result transactions, oldest first
	tmfs_out_t metrics_due[$];
	int        n_fail;
	int        n_checked;
	int        n_sent;
	int        n_status;
	int        n_leg;
	int        idle_cycles;
	bit        stim_done;
	bit        hold_off;

	// square-root helpers: 128-bit for the Heron root, 64-bit for leg and sine
	function automatic logic [63:0] root128(logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  c;
		r = '0;
		for (int bit_i = 53; bit_i >= 0; bit_i--) begin
			c = r | (64'd1 << bit_i);
			if ({64'd0, c} * {64'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int bit_i = 31; bit_i >= 0; bit_i--) begin
			c = r | (64'd1 << bit_i);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	// law of cosines, then CORDIC atan2 in degrees Q8.16, rounded to Q8.8
	function automatic logic [15:0] apex_angle(longint a, longint b, longint c);
		longint      num;
		longint      mag;
		longint      den;
		longint      q;
		longint      rem;
		longint      x;
		longint      y;
		longint      z;
		longint      nx;
		logic [63:0] yrad;
		num = (b * b + c * c) - a * a;
		den = 2 * b * c;
		mag = num < 0 ? -num : num;
		if (mag >= den)
			return num < 0 ? ANGLE_MAX : 16'd0;
		q = 0;
		rem = mag;
		for (int i = 0; i < 30; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q = q | 1;
			end
		end
		x = num < 0 ? -q : q;
		yrad = (64'd1 << 60) - 64'(x * x);
		y = longint'(root64(yrad));
		z = 0;
		if (x < 0) begin
			nx = y;
			y = -x;
			x = nx;
			z = longint'(Z_90);
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y >= 0) begin
				nx = x + shr_floor(y, i);
				y = y - shr_floor(x, i);
				z = z + longint'(ATAN_DEG[i]);
			end else begin
				nx = x - shr_floor(y, i);
				y = y + shr_floor(x, i);
				z = z - longint'(ATAN_DEG[i]);
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > longint'(Z_MAX)) z = longint'(Z_MAX);
		return 16'((z + 128) >>> 8);
	endfunction

	function automatic tmfs_out_t triangle_metrics(tmfs_in_t t);
		tmfs_out_t    r;
		logic [63:0]  a;
		logic [63:0]  b;
		logic [63:0]  c;
		logic [63:0]  root;
		logic [63:0]  alt;
		logic [63:0]  side;
		logic [127:0] prod;
		bit           match;
		a = 64'(t.opposite_length);
		b = 64'(t.adj_length);
		c = 64'(t.base_length);
		r = '0;
		root = '0;
		alt = '0;
		side = '0;
		match = 0;
		if (b + c > a && a + c > b && a + b > c) begin
			prod = 128'((a + b + c) * (b + c - a)) * 128'((a + c - b) * (a + b - c));
			root = root128(prod);
		end
		r.area = (root >> 10) > 64'hFF_FFFF_FFFF ? '1 : 40'(root >> 10);
		if (a == 0) begin
			r.status = 1'b1;
		end else begin
			alt = root / (2 * a);
			if (alt > 64'hFF_FFFF) alt = 64'hFF_FFFF;
		end
		r.altitude = 24'(alt);
		if (b == 0 || c == 0)
			r.status = 1'b1;
		else
			r.angle_degrees = apex_angle(longint'(a), longint'(b), longint'(c));
		if (t.base_target == t.query_node) begin
			side = c;
			match = 1;
		end
		if (t.adj_target == t.query_node) begin
			side = b;
			match = 1;
		end
		if (match && a != 0 && side > alt)
			r.leg_length = 24'(root64(side * side - alt * alt));
		return r;
	endfunction

	function automatic bit pick(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic int gap_len();
		return pick(85) ? $urandom_range(2) : $urandom_range(40);
	endfunction

	function automatic logic [23:0] rand_len();
		case ($urandom_range(4))
			0: return 24'($urandom_range(255));
			1: return 24'($urandom);
			2: return 24'hFF_FF00 | 24'($urandom_range(255));
			default: return 24'($urandom_range(20000));
		endcase
	endfunction

	// mostly valid triangles with a matching query id, some noise
	function automatic tmfs_in_t rand_triangle();
		tmfs_in_t    t;
		logic [23:0] lo;
		logic [23:0] hi;
		t.base_length = rand_len();
		t.adj_length = rand_len();
		if (pick(75)) begin
			lo = t.base_length > t.adj_length ? t.base_length - t.adj_length
			                                  : t.adj_length - t.base_length;
			hi = 24'((25'(t.base_length) + t.adj_length) > 25'hFF_FFFF ? 24'hFF_FFFF
			        : t.base_length + t.adj_length);
			t.opposite_length = hi > lo + 1 ? 24'($urandom_range(hi - 1, lo + 1)) : lo;
		end else begin
			t.opposite_length = rand_len();
		end
		t.base_target = 16'($urandom);
		t.adj_target = pick(15) ? t.base_target : 16'($urandom);
		case ($urandom_range(3))
			0: t.query_node = t.base_target;
			1: t.query_node = t.adj_target;
			2: t.query_node = pick(50) ? t.base_target : t.adj_target;
			default: t.query_node = 16'($urandom);
		endcase
		return t;
	endfunction

	function automatic tmfs_in_t mk(logic [23:0] c, logic [23:0] b, logic [23:0] a,
	                                logic [15:0] bt, logic [15:0] at, logic [15:0] qn);
		tmfs_in_t t;
		t.base_length = c;
		t.adj_length = b;
		t.opposite_length = a;
		t.base_target = bt;
		t.adj_target = at;
		t.query_node = qn;
		return t;
	endfunction

	function automatic tmfs_out_t res(logic [39:0] ar, logic [15:0] an, logic [23:0] al,
	                                  logic [23:0] lg, logic st);
		tmfs_out_t r;
		r.area = ar;
		r.angle_degrees = an;
		r.altitude = al;
		r.leg_length = lg;
		r.status = st;
		return r;
	endfunction

	// sender: one transaction per call, valid dropped only across a gap
	task automatic send_triangle(tmfs_in_t t, bit typed, tmfs_out_t want);
		int gap;
		gap = gap_len() * int'(pick(60));
		if (gap > 0) begin
			request.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request.valid <= 1'b1;
		request.data <= t;
		@(posedge clk);
		while (!request.ready) @(posedge clk);
		metrics_due.push_back(typed ? want : triangle_metrics(t));
		n_sent++;
	endtask

	initial begin
		dir_row_t dir_rows[$];
		clk = 1'b0;
		arst_n = 1'b0;
		request.valid = 1'b0;
		request.data = '0;
		stim_done = 0;
		n_fail = 0;
		n_checked = 0;
		n_sent = 0;
		n_status = 0;
		n_leg = 0;

		// all zero: degenerate, status set, nothing else
		dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 1)});
		// zero opposite side: degenerate line, angle 0 (cosine clamps to one)
		dir_rows.push_back('{mk(24'h100, 24'h100, 0, 1, 2, 3), 1, res(0, 0, 0, 0, 1)});
		// zero base side
		dir_rows.push_back('{mk(0, 24'h100, 24'h100, 1, 2, 2), 0, '0});
		// zero adjacent side
		dir_rows.push_back('{mk(24'h100, 0, 24'h100, 1, 2, 1), 0, '0});
		// flat triangle a = b + c: cosine clamps to minus one, angle 180
		dir_rows.push_back('{mk(24'h100, 24'h100, 24'h200, 5, 6, 7),
		                     1, res(0, ANGLE_MAX, 0, 0, 0)});
		// flat triangle c = a + b: angle 0, no match
		dir_rows.push_back('{mk(24'h300, 24'h100, 24'h200, 5, 6, 7), 1, res(0, 0, 0, 0, 0)});
		// impossible triangle
		dir_rows.push_back('{mk(24'h100, 24'h100, 24'hF000, 1, 1, 1), 0, '0});
		// 3-4-5 right triangle, each query choice, both-match case
		dir_rows.push_back('{mk(24'h400, 24'h300, 24'h500, 10, 20, 10), 0, '0});
		dir_rows.push_back('{mk(24'h400, 24'h300, 24'h500, 10, 20, 20), 0, '0});
		dir_rows.push_back('{mk(24'h400, 24'h300, 24'h500, 9, 9, 9), 0, '0});
		dir_rows.push_back('{mk(24'h400, 24'h300, 24'h500, 10, 20, 30), 0, '0});
		// equilateral, smallest and largest; thin isosceles with a unit opposite side
		dir_rows.push_back('{mk(1, 1, 1, 0, 16'hFFFF, 16'hFFFF), 0, '0});
		dir_rows.push_back('{mk('1, '1, '1, 16'hFFFF, 0, 16'hFFFF), 0, '0});
		dir_rows.push_back('{mk('1, '1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, '0});
		// obtuse, near-flat and tiny opposite
		dir_rows.push_back('{mk(24'h100, 24'h100, 24'h1FF, 1, 2, 1), 0, '0});
		dir_rows.push_back('{mk(24'hFFFFFF, 24'hFFFFFE, 1, 1, 2, 1), 0, '0});
		dir_rows.push_back('{mk(24'h800000, 24'h7FFFFF, 24'hFFFFFE, 1, 2, 2), 0, '0});
		dir_rows.push_back('{mk(24'h555555, 24'hAAAAAA, 24'h800000, 16'h5555, 16'hAAAA,
		                        16'hAAAA), 0, '0});
		dir_rows.push_back('{mk(24'hAAAAAA, 24'h555555, 24'h800000, 16'hAAAA, 16'h5555,
		                        16'hAAAA), 0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_triangle(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
		for (int i = 0; i < N_RANDOM; i++)
			send_triangle(rand_triangle(), 0, '0);
		request.valid <= 1'b0;
		stim_done = 1;
	end

	// receiver: random ready, plus one long hold-off to fill the pipe
	initial begin
		int hold_at;
		result.ready = 1'b0;
		hold_off = 0;
		hold_at = $urandom_range(300, 400);
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (n_checked >= hold_at && !hold_off) begin
				hold_off = 1;
				result.ready <= 1'b0;
				repeat (STALL_LONG) @(posedge clk);
				result.ready <= 1'b1;
			end else if (n_checked > 100 && n_checked < 200) begin
				result.ready <= 1'b1;
			end else begin
				result.ready <= pick(75) ? 1'b1 : (pick(90) ? 1'b0 : 1'b0);
				if (!pick(75))
					repeat (gap_len()) @(posedge clk);
			end
		end
	end

	// checker
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			tmfs_out_t want;
			tmfs_out_t got;
			got = result.data;
			if (metrics_due.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = metrics_due.pop_front();
				n_checked++;
				if (got.status) n_status++;
				if (got.leg_length != 0) n_leg++;
				if (got !== want) begin
					n_fail++;
					if (n_fail <= 10)
						$display("mismatch #%0d: area %h/%h angle %h/%h alt %h/%h leg %h/%h st %b/%b",
						         n_checked, want.area, got.area, want.angle_degrees,
						         got.angle_degrees, want.altitude, got.altitude,
						         want.leg_length, got.leg_length, want.status, got.status);
				end
			end
		end
	end

	// watchdog and end of run
	initial begin
		idle_cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((request.valid && request.ready) || (result.valid && result.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
			if (stim_done && metrics_due.size() == 0)
				break;
		end
		repeat (LATENCY + 20) @(posedge clk);
		$display("covered %0d triangles, %0d with status set, %0d with a leg, one long stall",
		         n_sent, n_status, n_leg);
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tmfs_pkg.sv
rtl/tmfs_ifs.sv
rtl/tmfs_sqrt_pipe.sv
rtl/triangle_metrics_from_sides_unit.sv
sim/triangle_metrics_from_sides_unit_tb.sv
